// ===== hdl/srf_pkg.sv =====
// Shared constants, types and the byte mask helper function of the slot ring FIFO.
package srf_pkg;

   localparam int SLOT_DEPTH  = 16;
   localparam int SLOT_WORDS  = 4;
   localparam int FIELD_WORDS = 4;
   localparam int WORD_W      = 64;
   localparam int ALIGN_BYTES = 8;
   localparam int LIVE_WORDS  = (SLOT_WORDS < FIELD_WORDS) ? SLOT_WORDS : FIELD_WORDS;
   localparam int ROW_W       = SLOT_WORDS * WORD_W;
   localparam int IDX_W       = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int CNT_W       = $clog2(SLOT_DEPTH + 1);
   localparam int CAP_W       = (CNT_W > 5) ? CNT_W : 5;
   localparam int BYTES_W     = 6;
   localparam int CAPCFG_W    = 5;
   localparam int FILL_W      = 5;
   localparam int TALLY_W     = 32;
   localparam int LIMIT_W     = 7;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [BYTES_W-1:0]  RESET_SLOT_BYTES    = 6'd32;
   localparam logic [CAPCFG_W-1:0] RESET_SLOT_CAPACITY = 5'd16;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   typedef enum logic {
      REG_SLOT_BYTES    = 1'b0,
      REG_SLOT_CAPACITY = 1'b1
   } csr_reg_type;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CAP_W-1:0]   cap_type;
   typedef logic [LIMIT_W-1:0] limit_type;

   typedef struct packed {
      logic               req_type;
      logic [WORD_W-1:0]  wr_w0;
      logic [WORD_W-1:0]  wr_w1;
      logic [WORD_W-1:0]  wr_w2;
      logic [WORD_W-1:0]  wr_w3;
      logic [BYTES_W-1:0] byte_count;
   } req_data_type;

   typedef struct packed {
      logic               ok;
      logic [WORD_W-1:0]  rd_w0;
      logic [WORD_W-1:0]  rd_w1;
      logic [WORD_W-1:0]  rd_w2;
      logic [WORD_W-1:0]  rd_w3;
      logic [FILL_W-1:0]  fill_level;
      logic [FILL_W-1:0]  peak_fill;
      logic [TALLY_W-1:0] pushes_done;
      logic [TALLY_W-1:0] pops_done;
      logic [TALLY_W-1:0] pushes_refused;
      logic [TALLY_W-1:0] pops_refused;
   } rsp_data_type;

   typedef struct packed {
      logic [BYTES_W-1:0]  slot_bytes;
      logic [CAPCFG_W-1:0] slot_capacity;
      logic                flush;
   } cfg_type;

   typedef struct packed {
      logic             wr_en;
      idx_type          wr_addr;
      logic [ROW_W-1:0] wr_row;
      logic             rd_en;
      idx_type          rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic [FILL_W-1:0]  fill_level;
      logic [FILL_W-1:0]  peak_fill;
      logic [TALLY_W-1:0] pushes_done;
      logic [TALLY_W-1:0] pops_done;
      logic [TALLY_W-1:0] pushes_refused;
      logic [TALLY_W-1:0] pops_refused;
   } stats_type;

   // Byte lanes of one word that lie below the byte count.
   function automatic logic [WORD_W-1:0] byte_mask(logic [BYTES_W-1:0] count, int word);
      logic [WORD_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < ALIGN_BYTES; b++) begin
         if ((word * ALIGN_BYTES + b) < int'(count)) begin
            mask[b*8 +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

// ===== hdl/slot_ring_fifo_with_stats.sv =====
// Top level of the slot ring FIFO with fill and request statistics.
// The block takes one request per cycle while req_stall is low and returns one result for each, in
// order. The slot memory's registered read and a one-entry pending stage hold a request during the
// read, and the result waits in an output register. A stall on the result side backs up through the
// pending stage to the request side. The slot memory needs no clearing after reset.
// A configuration write empties the queue and keeps the watermark and the tallies.
module slot_ring_fifo_with_stats (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  srf_pkg::req_data_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output srf_pkg::rsp_data_type       rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [srf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [srf_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [srf_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   srf_pkg::cfg_type              cfg;
   srf_pkg::mem_cmd_type          cmd;
   srf_pkg::stats_type            stats;
   logic [srf_pkg::ROW_W-1:0]     rd_row;
   logic                          accept, req_ok, out_free, advance;
   logic                          pend_ff, pend_in;
   logic                          pend_ok_ff;
   logic                          pend_pop_ff;
   logic [srf_pkg::BYTES_W-1:0]   pend_count_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   srf_pkg::rsp_data_type         rsp_data_ff, rsp_data_in;
   logic [srf_pkg::WORD_W-1:0]    rd_words [srf_pkg::FIELD_WORDS];

   srf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .req_ok (req_ok),
      .cmd    (cmd),
      .stats  (stats)
   );

   srf_store u_store (
      .clock  (clock),
      .cmd    (cmd),
      .rd_row (rd_row)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = pend_ff && out_free;
   assign req_stall = pend_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int w = 0; w < srf_pkg::FIELD_WORDS; w++) begin
         rd_words[w] = '0;
      end
      for (int w = 0; w < srf_pkg::LIVE_WORDS; w++) begin
         if (pend_ok_ff && pend_pop_ff) begin
            rd_words[w] = rd_row[w*srf_pkg::WORD_W +: srf_pkg::WORD_W] &
                          srf_pkg::byte_mask(pend_count_ff, w);
         end
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         pend_in                    = 1'b0;
         rsp_valid_in               = 1'b1;
         rsp_data_in.ok             = pend_ok_ff;
         rsp_data_in.rd_w0          = rd_words[0];
         rsp_data_in.rd_w1          = rd_words[1];
         rsp_data_in.rd_w2          = rd_words[2];
         rsp_data_in.rd_w3          = rd_words[3];
         rsp_data_in.fill_level     = stats.fill_level;
         rsp_data_in.peak_fill      = stats.peak_fill;
         rsp_data_in.pushes_done    = stats.pushes_done;
         rsp_data_in.pops_done      = stats.pops_done;
         rsp_data_in.pushes_refused = stats.pushes_refused;
         rsp_data_in.pops_refused   = stats.pops_refused;
      end
      if (accept) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         pend_ok_ff    <= req_ok;
         pend_pop_ff   <= (req_data.req_type == srf_pkg::REQ_DEQUEUE);
         pend_count_ff <= req_data.byte_count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/srf_csr.sv =====
// Configuration register port of the slot ring FIFO.
module srf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [srf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [srf_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [srf_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output srf_pkg::cfg_type            cfg
);

   logic [srf_pkg::BYTES_W-1:0]  slot_bytes_ff, slot_bytes_in;
   logic [srf_pkg::CAPCFG_W-1:0] slot_capacity_ff, slot_capacity_in;
   logic                         write_hit;
   srf_pkg::csr_reg_type         reg_sel;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = srf_pkg::csr_reg_type'(csr_paddr[2]);

   always_comb begin
      slot_bytes_in    = slot_bytes_ff;
      slot_capacity_in = slot_capacity_ff;
      csr_prdata       = '0;
      case (reg_sel)
         srf_pkg::REG_SLOT_BYTES: begin
            csr_prdata = srf_pkg::DATA_W'(slot_bytes_ff);
            if (write_hit) begin
               slot_bytes_in = csr_pwdata[srf_pkg::BYTES_W-1:0];
            end
         end
         srf_pkg::REG_SLOT_CAPACITY: begin
            csr_prdata = srf_pkg::DATA_W'(slot_capacity_ff);
            if (write_hit) begin
               slot_capacity_in = csr_pwdata[srf_pkg::CAPCFG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff    <= srf_pkg::RESET_SLOT_BYTES;
         slot_capacity_ff <= srf_pkg::RESET_SLOT_CAPACITY;
      end else begin
         slot_bytes_ff    <= slot_bytes_in;
         slot_capacity_ff <= slot_capacity_in;
      end
   end

   assign cfg.slot_bytes    = slot_bytes_ff;
   assign cfg.slot_capacity = slot_capacity_ff;
   assign cfg.flush         = write_hit;

endmodule

// ===== hdl/srf_store.sv =====
// Slot memory: one row of all words per slot, one write and one registered read port.
module srf_store (
   input  logic                       clock,
   input  srf_pkg::mem_cmd_type       cmd,
   output logic [srf_pkg::ROW_W-1:0]  rd_row
);

   logic [srf_pkg::ROW_W-1:0] slot_mem [srf_pkg::SLOT_DEPTH];
   logic [srf_pkg::ROW_W-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[cmd.wr_addr] <= cmd.wr_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= slot_mem[cmd.rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

// ===== hdl/srf_ctrl.sv =====
// Queue control: pointers, fill level, watermark, tallies and memory commands.
module srf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  srf_pkg::req_data_type req,
   input  srf_pkg::cfg_type      cfg,
   output logic                  req_ok,
   output srf_pkg::mem_cmd_type  cmd,
   output srf_pkg::stats_type    stats
);

   srf_pkg::idx_type              head_ff, head_in;
   srf_pkg::idx_type              tail_ff, tail_in;
   srf_pkg::cap_type              occ_ff, occ_in;
   srf_pkg::cap_type              peak_ff, peak_in;
   logic [srf_pkg::TALLY_W-1:0]   push_ok_ff, push_ok_in;
   logic [srf_pkg::TALLY_W-1:0]   pop_ok_ff, pop_ok_in;
   logic [srf_pkg::TALLY_W-1:0]   push_bad_ff, push_bad_in;
   logic [srf_pkg::TALLY_W-1:0]   pop_bad_ff, pop_bad_in;
   srf_pkg::cap_type              cap_now;
   srf_pkg::cap_type              cap_cfg;
   srf_pkg::cap_type              head_inc, tail_inc;
   srf_pkg::limit_type            rounded, limit;
   logic                          size_ok, push_ok, pop_ok, is_pop;
   logic [srf_pkg::WORD_W-1:0]    in_words [srf_pkg::FIELD_WORDS];
   logic [srf_pkg::ROW_W-1:0]     wr_row;

   localparam srf_pkg::limit_type LIMIT_TOP =
      srf_pkg::limit_type'(srf_pkg::LIVE_WORDS * srf_pkg::ALIGN_BYTES);
   localparam srf_pkg::limit_type ALIGN_MASK =
      srf_pkg::limit_type'(srf_pkg::ALIGN_BYTES - 1);

   assign cap_cfg = srf_pkg::cap_type'(cfg.slot_capacity);
   assign cap_now = (cap_cfg > srf_pkg::cap_type'(srf_pkg::SLOT_DEPTH)) ?
                    srf_pkg::cap_type'(srf_pkg::SLOT_DEPTH) : cap_cfg;

   assign rounded = (srf_pkg::limit_type'(cfg.slot_bytes) + ALIGN_MASK) & ~ALIGN_MASK;
   assign limit   = (rounded > LIMIT_TOP) ? LIMIT_TOP : rounded;
   assign size_ok = (req.byte_count != '0) &&
                    (srf_pkg::limit_type'(req.byte_count) <= limit);

   assign is_pop  = (req.req_type == srf_pkg::REQ_DEQUEUE);
   assign push_ok = size_ok && (occ_ff < cap_now);
   assign pop_ok  = size_ok && (occ_ff != '0);
   assign req_ok  = is_pop ? pop_ok : push_ok;

   assign head_inc = srf_pkg::cap_type'(head_ff) + srf_pkg::cap_type'(1);
   assign tail_inc = srf_pkg::cap_type'(tail_ff) + srf_pkg::cap_type'(1);

   assign in_words[0] = req.wr_w0;
   assign in_words[1] = req.wr_w1;
   assign in_words[2] = req.wr_w2;
   assign in_words[3] = req.wr_w3;

   always_comb begin
      wr_row = '0;
      for (int w = 0; w < srf_pkg::LIVE_WORDS; w++) begin
         wr_row[w*srf_pkg::WORD_W +: srf_pkg::WORD_W] =
            in_words[w] & srf_pkg::byte_mask(req.byte_count, w);
      end
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      peak_in     = peak_ff;
      push_ok_in  = push_ok_ff;
      pop_ok_in   = pop_ok_ff;
      push_bad_in = push_bad_ff;
      pop_bad_in  = pop_bad_ff;
      if (cfg.flush) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end else if (accept) begin
         if (!is_pop) begin
            if (push_ok) begin
               tail_in    = (tail_inc >= cap_now) ? '0 : srf_pkg::idx_type'(tail_inc);
               occ_in     = occ_ff + srf_pkg::cap_type'(1);
               push_ok_in = push_ok_ff + 1'b1;
               if (occ_in > peak_ff) begin
                  peak_in = occ_in;
               end
            end else begin
               push_bad_in = push_bad_ff + 1'b1;
            end
         end else begin
            if (pop_ok) begin
               head_in   = (head_inc >= cap_now) ? '0 : srf_pkg::idx_type'(head_inc);
               occ_in    = occ_ff - srf_pkg::cap_type'(1);
               pop_ok_in = pop_ok_ff + 1'b1;
            end else begin
               pop_bad_in = pop_bad_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         occ_ff      <= '0;
         peak_ff     <= '0;
         push_ok_ff  <= '0;
         pop_ok_ff   <= '0;
         push_bad_ff <= '0;
         pop_bad_ff  <= '0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         occ_ff      <= occ_in;
         peak_ff     <= peak_in;
         push_ok_ff  <= push_ok_in;
         pop_ok_ff   <= pop_ok_in;
         push_bad_ff <= push_bad_in;
         pop_bad_ff  <= pop_bad_in;
      end
   end

   assign cmd.wr_en   = accept && !is_pop && push_ok;
   assign cmd.wr_addr = tail_ff;
   assign cmd.wr_row  = wr_row;
   assign cmd.rd_en   = accept && is_pop && pop_ok;
   assign cmd.rd_addr = head_ff;

   assign stats.fill_level     = occ_ff[srf_pkg::FILL_W-1:0];
   assign stats.peak_fill      = peak_ff[srf_pkg::FILL_W-1:0];
   assign stats.pushes_done    = push_ok_ff;
   assign stats.pops_done      = pop_ok_ff;
   assign stats.pushes_refused = push_bad_ff;
   assign stats.pops_refused   = pop_bad_ff;

endmodule
